// ----- rtl/joint_impedance_trajectory_control_macros.svh -----
// Assertion macros used by the checker file.
// The clock i_clk and the active-low reset i_rst_n must be in scope.
`ifndef JOINT_IMPEDANCE_TRAJECTORY_CONTROL_MACROS_SVH
`define JOINT_IMPEDANCE_TRAJECTORY_CONTROL_MACROS_SVH

// Same-cycle implication.
`define JITC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define JITC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/jitc_pkg.sv -----
// ----------------------------------------------------------------------------
// jitc_pkg
// Shared types, codes and helpers of the joint impedance trajectory controller.
// ----------------------------------------------------------------------------
package jitc_pkg;

    localparam int QFRAC  = 16;
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;
    localparam int DIV_NW = 64;
    localparam int DIV_DW = 32;

    localparam int ONE_MINUS_ALPHA_Q = 655;
    localparam int ALPHA_Q           = 64881;
    localparam int VEL_SCALE         = 1000000;

    typedef logic [2:0] t_opcode;
    localparam t_opcode OP_LOAD_POINT = 3'd0;
    localparam t_opcode OP_COMMIT     = 3'd1;
    localparam t_opcode OP_LOAD_STIFF = 3'd2;
    localparam t_opcode OP_LOAD_DAMP  = 3'd3;
    localparam t_opcode OP_SAMPLE     = 3'd4;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_CORIOLIS   = 2'd0;
    localparam t_reg_idx REG_INTERVAL   = 2'd1;
    localparam t_reg_idx REG_STEP_LIMIT = 2'd2;

    localparam logic signed [31:0] RST_CORIOLIS   = 32'sd65536;
    localparam logic [15:0]        RST_INTERVAL   = 16'd1000;
    localparam logic [30:0]        RST_STEP_LIMIT = 31'd65536;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_NW-1:0] quot;
        logic              rem_nz;
    } t_div_rsp;

    localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(64'sh7FFF_FFFF);
    localparam logic signed [PROD_W-1:0] SAT_LO = ~SAT_HI;

    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < SAT_LO) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/jitc_ram.sv -----
// ----------------------------------------------------------------------------
// jitc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module jitc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/jitc_mul.sv -----
// ----------------------------------------------------------------------------
// jitc_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module jitc_mul import jitc_pkg::*; (
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// ----- rtl/jitc_div.sv -----
// ----------------------------------------------------------------------------
// jitc_div
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module jitc_div import jitc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(DIV_NW + 1);

    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIV_NW-1:0] r_quot;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_DW:0]   w_shift;
    logic [DIV_DW:0]   w_diff;
    logic              w_ge;

    assign w_shift = {r_rem, r_quot[DIV_NW-1]};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_ge    = w_shift >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quot <= i_req.dividend;
            r_rem  <= '0;
            r_den  <= i_req.divisor;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[DIV_DW-1:0] : w_shift[DIV_DW-1:0];
            r_quot <= {r_quot[DIV_NW-2:0], w_ge};
        end
    end

    assign o_rsp.busy   = r_busy;
    assign o_rsp.done   = r_done;
    assign o_rsp.quot   = r_quot;
    assign o_rsp.rem_nz = |r_rem;

endmodule

// ----- rtl/joint_impedance_trajectory_control.sv -----
// A joint-sample request makes two waits on the radix-2 divider, each for its 64-bit
// quotient plus the done strobe, first for normalized time and then for target
// velocity. The other sequencer steps share one multiplier with a registered product.
// A zero point interval skips both divider waits and the velocity scaling. A load
// point request passes through a RAM write step. The other loads, commit, and ignored
// or unknown requests return to idle from decode, and a sample while unarmed or with
// fewer than two points goes from decode to the output step. The block takes one
// request at a time, and s_axis_tready is high only while the sequencer is idle.
// A finished torque waits in the output register while the next request is taken. A
// second torque stays in the sequencer until that register is free, which adds stall
// cycles. Waypoints live in a RAM that is read one word per cycle.
// ----------------------------------------------------------------------------
// joint_impedance_trajectory_control
// Per-joint impedance controller following a stored quintic-timed trajectory.
// ----------------------------------------------------------------------------
module joint_impedance_trajectory_control import jitc_pkg::*; #(
    parameter int MAX_POINTS = 1024,
    parameter int JOINTS     = 7
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // point_index[10:0], load_value[42:11], period_us[58:43], measured_position[90:59],
    // measured_velocity[122:91], coriolis_torque[154:123], prior_torque[186:155]
    input  logic [191:0] s_axis_tdata,
    // opcode[2:0], joint_index[5:3]
    input  logic [5:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // torque_command[31:0]
    output logic [31:0]  m_axis_tdata,
    // joint_out[2:0]
    output logic [2:0]   m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int AW  = $clog2(MAX_POINTS * JOINTS);
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int JIW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DEC, ST_WR, ST_TDIV, ST_TWAIT, ST_T2, ST_T3, ST_T4, ST_T5,
        ST_POLY, ST_SN, ST_SEG, ST_ADDR, ST_RD0, ST_RD1, ST_P1, ST_POS, ST_VELM,
        ST_VELD, ST_VWAIT, ST_VDS, ST_F1, ST_F2, ST_F3, ST_K, ST_D, ST_TQ, ST_RL,
        ST_OUT
    } t_state;

    t_state r_state;

    // configuration
    logic signed [31:0] r_cs;
    logic [15:0]        r_interval;
    logic [30:0]        r_step_lim;

    // captured request
    t_opcode            r_op;
    logic [2:0]         r_j;
    logic [10:0]        r_pidx;
    logic signed [31:0] r_load;
    logic [15:0]        r_period;
    logic signed [31:0] r_mpos;
    logic signed [31:0] r_mvel;
    logic signed [31:0] r_cor;
    logic signed [31:0] r_prior;

    // controller state
    logic [CW-1:0]      r_count;
    logic [31:0]        r_elapsed;
    logic               r_armed;
    logic signed [31:0] r_stiff [JOINTS];
    logic signed [31:0] r_damp  [JOINTS];
    logic signed [31:0] r_fvel  [JOINTS];

    // working registers
    logic [16:0]              r_t;
    logic [16:0]              r_t2;
    logic [16:0]              r_t3;
    logic [16:0]              r_t4;
    logic [16:0]              r_s;
    logic [17:0]              r_ds;
    logic [CW-1:0]            r_seg;
    logic [16:0]              r_lt;
    logic [AW-1:0]            r_addr;
    logic signed [31:0]       r_p0;
    logic signed [32:0]       r_diff;
    logic signed [31:0]       r_pos;
    logic signed [31:0]       r_vel;
    logic                     r_neg;
    logic signed [31:0]       r_f;
    logic signed [PROD_W-1:0] r_acc;
    logic signed [31:0]       r_tq;
    logic signed [31:0]       r_res;

    logic               r_ovalid;
    logic [2:0]         r_ojoint;
    logic signed [31:0] r_otorque;

    logic signed [MUL_W-1:0]  w_ma;
    logic signed [MUL_W-1:0]  w_mb;
    logic signed [PROD_W-1:0] w_p;
    logic signed [PROD_W-1:0] w_pq;
    t_div_req                 w_dreq;
    t_div_rsp                 w_drsp;
    logic                     w_we;
    logic [AW-1:0]            w_waddr;
    logic [AW-1:0]            w_raddr;
    logic [31:0]              w_rdata;

    logic               w_accept;
    logic               w_cfg_wr;
    logic [JIW-1:0]     w_jx;
    logic               w_j_ok;
    logic               w_pidx_ok;
    logic [CW-1:0]      w_n;
    logic [32:0]        w_esum;
    logic signed [23:0] w_t2e;
    logic signed [23:0] w_t3e;
    logic signed [23:0] w_t4e;
    logic signed [23:0] w_t5e;
    logic signed [23:0] w_s_raw;
    logic signed [23:0] w_ds_raw;
    logic [CW-1:0]      w_seg_raw;
    logic               w_seg_clamp;
    logic [AW-1:0]      w_addr0;
    logic [63:0]        w_pabs;
    logic [DIV_NW:0]    w_vmag;
    logic signed [31:0] w_vdiv;
    logic signed [PROD_W-1:0] w_dlt;
    logic signed [PROD_W-1:0] w_lim;

    assign w_accept  = s_axis_tvalid && s_axis_tready;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_jx      = JIW'(r_j);
    assign w_j_ok    = int'(r_j) < JOINTS;
    assign w_pidx_ok = int'(r_pidx) < MAX_POINTS;
    assign w_n       = r_count - CW'(1);
    assign w_esum    = {1'b0, r_elapsed} + 33'(r_period);
    assign w_pq      = w_p >>> QFRAC;

    // quintic smoothing terms
    assign w_t2e    = 24'(r_t2);
    assign w_t3e    = 24'(r_t3);
    assign w_t4e    = 24'(r_t4);
    assign w_t5e    = 24'(w_pq[16:0]);
    assign w_s_raw  = 24'sd10 * w_t3e - 24'sd15 * w_t4e + 24'sd6 * w_t5e;
    assign w_ds_raw = 24'sd30 * w_t2e - 24'sd60 * w_t3e + 24'sd30 * w_t4e;

    assign w_seg_raw   = w_p[QFRAC+CW-1:QFRAC];
    assign w_seg_clamp = w_seg_raw >= w_n;
    assign w_addr0     = w_p[AW-1:0] + AW'(r_j);

    assign w_pabs = w_p[PROD_W-1] ? (~w_p[63:0] + 64'd1) : w_p[63:0];
    assign w_vmag = {1'b0, w_drsp.quot} + (DIV_NW+1)'(w_drsp.rem_nz);

    // floored signed quotient of the velocity division, saturated
    always_comb begin
        if (!r_neg) begin
            w_vdiv = (w_drsp.quot > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : w_drsp.quot[31:0];
        end else if (w_vmag > 65'h8000_0000) begin
            w_vdiv = 32'sh8000_0000;
        end else begin
            w_vdiv = ~w_vmag[31:0] + 32'd1;
        end
    end

    // rate limit on the change from the prior torque
    assign w_lim = PROD_W'(r_step_lim);
    always_comb begin
        w_dlt = PROD_W'(r_tq) - PROD_W'(r_prior);
        if (w_dlt > w_lim) begin
            w_dlt = w_lim;
        end else if (w_dlt < -w_lim) begin
            w_dlt = -w_lim;
        end
    end

    // multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            ST_DEC: begin
                if (r_op == OP_SAMPLE) begin
                    w_ma = MUL_W'(w_n);
                    w_mb = MUL_W'(r_interval);
                end else begin
                    w_ma = MUL_W'(r_pidx);
                    w_mb = MUL_W'(JOINTS);
                end
            end
            ST_T2: begin
                w_ma = MUL_W'(r_t);
                w_mb = MUL_W'(r_t);
            end
            ST_T3, ST_T4, ST_T5: begin
                w_ma = MUL_W'(w_pq[16:0]);
                w_mb = MUL_W'(r_t);
            end
            ST_SN: begin
                w_ma = MUL_W'(r_s);
                w_mb = MUL_W'(w_n);
            end
            ST_ADDR: begin
                w_ma = MUL_W'(r_seg);
                w_mb = MUL_W'(JOINTS);
            end
            ST_POS: begin
                w_ma = MUL_W'(r_diff);
                w_mb = MUL_W'(r_lt);
            end
            ST_VELM: begin
                w_ma = MUL_W'(r_diff);
                w_mb = MUL_W'(VEL_SCALE);
            end
            ST_VDS: begin
                w_ma = MUL_W'(r_vel);
                w_mb = MUL_W'(r_ds);
            end
            ST_F1: begin
                w_ma = MUL_W'(ONE_MINUS_ALPHA_Q);
                w_mb = MUL_W'(r_fvel[w_jx]);
            end
            ST_F2: begin
                w_ma = MUL_W'(ALPHA_Q);
                w_mb = MUL_W'(r_mvel);
            end
            ST_F3: begin
                w_ma = MUL_W'(r_cs);
                w_mb = MUL_W'(r_cor);
            end
            ST_K: begin
                w_ma = MUL_W'(r_stiff[w_jx]);
                w_mb = MUL_W'(sat32(PROD_W'(r_pos) - PROD_W'(r_mpos)));
            end
            ST_D: begin
                w_ma = MUL_W'(r_damp[w_jx]);
                w_mb = MUL_W'(sat32(PROD_W'(r_vel) - PROD_W'(r_f)));
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // divider request
    always_comb begin
        w_dreq.start    = 1'b0;
        w_dreq.dividend = {16'd0, r_elapsed, 16'd0};
        w_dreq.divisor  = w_p[31:0];
        if (r_state == ST_TDIV) begin
            w_dreq.start = w_p[31:0] != 32'd0;
        end else if (r_state == ST_VELD) begin
            w_dreq.start    = r_interval != 16'd0;
            w_dreq.dividend = w_pabs;
            w_dreq.divisor  = 32'(r_interval);
        end
    end

    assign w_we    = (r_state == ST_WR);
    assign w_waddr = w_addr0;
    assign w_raddr = (r_state == ST_RD0) ? w_addr0 : (r_addr + AW'(JOINTS));

    jitc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_ma),
        .i_b    (w_mb),
        .o_prod (w_p)
    );

    jitc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_rsp   (w_drsp)
    );

    jitc_ram #(
        .WIDTH (32),
        .DEPTH (MAX_POINTS * JOINTS)
    ) u_wp_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_load),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs       <= RST_CORIOLIS;
            r_interval <= RST_INTERVAL;
            r_step_lim <= RST_STEP_LIMIT;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_CORIOLIS:   r_cs       <= pwdata;
                REG_INTERVAL:   r_interval <= pwdata[15:0];
                REG_STEP_LIMIT: r_step_lim <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_CORIOLIS:   prdata = r_cs;
            REG_INTERVAL:   prdata = {16'd0, r_interval};
            REG_STEP_LIMIT: prdata = {1'b0, r_step_lim};
            default:        prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ovalid  <= 1'b0;
            r_count   <= '0;
            r_elapsed <= '0;
            r_armed   <= 1'b0;
            for (int k = 0; k < JOINTS; k++) begin
                r_fvel[k] <= '0;
            end
        end else begin
            // ST_OUT reloads the output register itself
            if (m_axis_tvalid && m_axis_tready && (r_state != ST_OUT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_op     <= s_axis_tuser[2:0];
                        r_j      <= s_axis_tuser[5:3];
                        r_pidx   <= s_axis_tdata[10:0];
                        r_load   <= s_axis_tdata[42:11];
                        r_period <= s_axis_tdata[58:43];
                        r_mpos   <= s_axis_tdata[90:59];
                        r_mvel   <= s_axis_tdata[122:91];
                        r_cor    <= s_axis_tdata[154:123];
                        r_prior  <= s_axis_tdata[186:155];
                        r_state  <= ST_DEC;
                    end
                end
                ST_DEC: begin
                    r_state <= ST_IDLE;
                    unique case (r_op)
                        OP_LOAD_POINT: begin
                            if (w_j_ok && w_pidx_ok) begin
                                r_state <= ST_WR;
                            end
                        end
                        OP_COMMIT: begin
                            r_count   <= (int'(r_pidx) > MAX_POINTS) ? CW'(MAX_POINTS)
                                                                     : CW'(r_pidx);
                            r_elapsed <= '0;
                            r_armed   <= 1'b1;
                        end
                        OP_LOAD_STIFF: begin
                            if (w_j_ok) begin
                                r_stiff[w_jx] <= r_load;
                            end
                        end
                        OP_LOAD_DAMP: begin
                            if (w_j_ok) begin
                                r_damp[w_jx] <= r_load;
                            end
                        end
                        OP_SAMPLE: begin
                            if (w_j_ok) begin
                                if (!r_armed || r_count < CW'(2)) begin
                                    r_res   <= '0;
                                    r_state <= ST_OUT;
                                end else begin
                                    if (r_j == 3'd0) begin
                                        r_elapsed <= w_esum[32] ? 32'hFFFF_FFFF
                                                                : w_esum[31:0];
                                    end
                                    r_state <= ST_TDIV;
                                end
                            end
                        end
                        default: r_state <= ST_IDLE;
                    endcase
                end
                ST_WR: begin
                    r_state <= ST_IDLE;
                end
                ST_TDIV: begin
                    if (w_p[31:0] == 32'd0) begin
                        r_t     <= 17'd65536;
                        r_state <= ST_T2;
                    end else begin
                        r_state <= ST_TWAIT;
                    end
                end
                ST_TWAIT: begin
                    if (w_drsp.done) begin
                        r_t     <= (w_drsp.quot > 64'd65536) ? 17'd65536 : w_drsp.quot[16:0];
                        r_state <= ST_T2;
                    end
                end
                ST_T2: r_state <= ST_T3;
                ST_T3: begin
                    r_t2    <= w_pq[16:0];
                    r_state <= ST_T4;
                end
                ST_T4: begin
                    r_t3    <= w_pq[16:0];
                    r_state <= ST_T5;
                end
                ST_T5: begin
                    r_t4    <= w_pq[16:0];
                    r_state <= ST_POLY;
                end
                ST_POLY: begin
                    if (w_s_raw < 0) begin
                        r_s <= '0;
                    end else if (w_s_raw > 24'sd65536) begin
                        r_s <= 17'd65536;
                    end else begin
                        r_s <= w_s_raw[16:0];
                    end
                    r_ds    <= (w_ds_raw < 0) ? 18'd0 : w_ds_raw[17:0];
                    r_state <= ST_SN;
                end
                ST_SN: r_state <= ST_SEG;
                ST_SEG: begin
                    // a full sweep lands on the end of the last segment
                    r_seg   <= w_seg_clamp ? (w_n - CW'(1)) : w_seg_raw;
                    r_lt    <= w_seg_clamp ? 17'd65536 : {1'b0, w_p[15:0]};
                    r_state <= ST_ADDR;
                end
                ST_ADDR: r_state <= ST_RD0;
                ST_RD0: begin
                    r_addr  <= w_addr0;
                    r_state <= ST_RD1;
                end
                ST_RD1: begin
                    r_p0    <= w_rdata;
                    r_state <= ST_P1;
                end
                ST_P1: begin
                    r_diff  <= 33'($signed(w_rdata)) - 33'(r_p0);
                    r_state <= ST_POS;
                end
                ST_POS: r_state <= ST_VELM;
                ST_VELM: begin
                    r_pos   <= sat32(PROD_W'(r_p0) + w_pq);
                    r_state <= ST_VELD;
                end
                ST_VELD: begin
                    r_neg <= w_p[PROD_W-1];
                    if (r_interval == 16'd0) begin
                        r_vel   <= '0;
                        r_state <= ST_F1;
                    end else begin
                        r_state <= ST_VWAIT;
                    end
                end
                ST_VWAIT: begin
                    if (w_drsp.done) begin
                        r_vel   <= w_vdiv;
                        r_state <= ST_VDS;
                    end
                end
                ST_VDS: r_state <= ST_F1;
                ST_F1: begin
                    if (r_interval != 16'd0) begin
                        r_vel <= sat32(w_pq);
                    end
                    r_state <= ST_F2;
                end
                ST_F2: begin
                    r_acc   <= w_p;
                    r_state <= ST_F3;
                end
                ST_F3: begin
                    r_f           <= sat32((r_acc + w_p) >>> QFRAC);
                    r_fvel[w_jx]  <= sat32((r_acc + w_p) >>> QFRAC);
                    r_state       <= ST_K;
                end
                ST_K: begin
                    r_acc   <= w_pq;
                    r_state <= ST_D;
                end
                ST_D: begin
                    r_acc   <= r_acc + w_pq;
                    r_state <= ST_TQ;
                end
                ST_TQ: begin
                    r_tq    <= sat32(r_acc + w_pq);
                    r_state <= ST_RL;
                end
                ST_RL: begin
                    r_res   <= sat32(PROD_W'(r_prior) + w_dlt);
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    // hold until the output register is free
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid  <= 1'b1;
                        r_ojoint  <= r_j;
                        r_otorque <= r_res;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_otorque;
    assign m_axis_tuser  = r_ojoint;

endmodule

// ----- rtl/jitc_checker.sv -----
// ----------------------------------------------------------------------------
// jitc_checker
// Port-level checks of the joint impedance trajectory controller.
// ----------------------------------------------------------------------------
`include "joint_impedance_trajectory_control_macros.svh"

module jitc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    // a stalled result holds
    `JITC_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // one request at a time: busy right after an accept
    `JITC_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // a new result appears only out of a busy sequencer
    `JITC_ASSERT_IMP(a_result_from_busy, $rose(m_axis_tvalid), !$past(s_axis_tready))

endmodule

bind joint_impedance_trajectory_control jitc_checker u_jitc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- tb/jitc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jitc_scoreboard
// Watches the request and result streams and the register port, keeps a
// predictor of the controller, and compares each torque command in order.
// ----------------------------------------------------------------------------
module jitc_scoreboard import jitc_pkg::*; #(
    parameter int MAX_POINTS = 1024,
    parameter int JOINTS     = 7
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,
    input  logic [5:0]   s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [31:0]  m_axis_tdata,
    input  logic [2:0]   m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output int           o_fail_count,
    output int           o_pending
);

    typedef struct packed {
        logic [2:0]  joint;
        logic [31:0] torque;
    } t_torque_cmd;

    logic [31:0]        waypoints [MAX_POINTS*JOINTS];
    logic signed [31:0] stiffness [JOINTS];
    logic signed [31:0] damping [JOINTS];
    logic signed [31:0] vel_filt [JOINTS];
    logic [31:0]        elapsed_us;
    logic [10:0]        n_points;
    logic               is_armed;
    logic signed [31:0] cor_scale;
    logic [15:0]        interval_us;
    logic [30:0]        step_limit;
    t_torque_cmd        torque_q [$];

    function automatic longint fdiv(input longint a, input longint d);
        longint q;
        q = a / d;
        if ((a % d) != 0 && ((a < 0) != (d < 0))) q -= 1;
        return q;
    endfunction

    function automatic longint qm(input longint a, input longint b);
        return fdiv(a * b, 65536);
    endfunction

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Advance the predictor by one request; queue a torque command if one results.
    task automatic predict_torque(input logic [191:0] d, input logic [5:0] u);
        t_opcode     op;
        logic [2:0]  j;
        logic [10:0] pidx;
        longint load, q, dq, cor, prior, tq, s, ds, t, t2, t3, t4, t5, n, sn, seg, lt;
        longint p0, p1, pos, vel, f, dlt, lim, e;
        longint unsigned dur, tt;
        t_torque_cmd c;
        op    = u[2:0];
        j     = u[5:3];
        pidx  = d[10:0];
        load  = longint'($signed(d[42:11]));
        q     = longint'($signed(d[90:59]));
        dq    = longint'($signed(d[122:91]));
        cor   = longint'($signed(d[154:123]));
        prior = longint'($signed(d[186:155]));
        case (op)
            OP_LOAD_POINT: begin
                if (j < JOINTS && pidx < MAX_POINTS) waypoints[pidx*JOINTS + j] = d[42:11];
            end
            OP_COMMIT: begin
                n_points   = (pidx > MAX_POINTS) ? 11'(MAX_POINTS) : pidx;
                elapsed_us = '0;
                is_armed   = 1'b1;
            end
            OP_LOAD_STIFF: if (j < JOINTS) stiffness[j] = 32'(load);
            OP_LOAD_DAMP:  if (j < JOINTS) damping[j] = 32'(load);
            OP_SAMPLE: if (j < JOINTS) begin
                c.joint = j;
                if (!is_armed || n_points < 2) begin
                    c.torque = '0;
                end else begin
                    if (j == 0) begin
                        e = longint'(elapsed_us) + longint'(d[58:43]);
                        elapsed_us = (e > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : e[31:0];
                    end
                    n = n_points - 1;
                    dur = n * interval_us;
                    if (dur == 0) t = 65536;
                    else begin
                        tt = (longint'(elapsed_us) << 16) / dur;
                        t = (tt > 65536) ? 65536 : tt;
                    end
                    t2 = qm(t, t); t3 = qm(t2, t); t4 = qm(t3, t); t5 = qm(t4, t);
                    s = 10*t3 - 15*t4 + 6*t5;
                    if (s < 0) s = 0;
                    if (s > 65536) s = 65536;
                    ds = 30*t2 - 60*t3 + 30*t4;
                    if (ds < 0) ds = 0;
                    sn = s * n;
                    seg = sn / 65536;
                    if (seg > n - 1) seg = n - 1;
                    lt = sn - seg * 65536;
                    p0 = longint'($signed(waypoints[seg*JOINTS + j]));
                    p1 = longint'($signed(waypoints[(seg+1)*JOINTS + j]));
                    pos = clip32(p0 + qm(p1 - p0, lt));
                    if (interval_us == 0) vel = 0;
                    else begin
                        vel = clip32(fdiv((p1 - p0) * 1000000, longint'(interval_us)));
                        vel = clip32(qm(vel, ds));
                    end
                    f = clip32(fdiv(655 * longint'(vel_filt[j]) + 64881 * dq, 65536));
                    vel_filt[j] = 32'(f);
                    tq = qm(cor_scale, cor) + qm(stiffness[j], clip32(pos - q))
                       + qm(damping[j], clip32(vel - f));
                    tq = clip32(tq);
                    lim = step_limit;
                    dlt = tq - prior;
                    if (dlt > lim) dlt = lim;
                    if (dlt < -lim) dlt = -lim;
                    tq = clip32(prior + dlt);
                    c.torque = tq[31:0];
                end
                torque_q = {torque_q, c};
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_torque_cmd exp_cmd;
        if (!i_rst_n) begin
            for (int k = 0; k < JOINTS; k++) begin
                vel_filt[k] = '0;
                stiffness[k] = '0;
                damping[k] = '0;
            end
            elapsed_us = '0;
            n_points   = '0;
            is_armed   = 1'b0;
            cor_scale  = RST_CORIOLIS;
            interval_us = RST_INTERVAL;
            step_limit = RST_STEP_LIMIT;
            torque_q.delete();
            o_fail_count = 0;
        end else begin
            if (psel && penable && pwrite) begin
                case (t_reg_idx'(paddr[3:2]))
                    REG_CORIOLIS:   cor_scale = pwdata;
                    REG_INTERVAL:   interval_us = pwdata[15:0];
                    REG_STEP_LIMIT: step_limit = pwdata[30:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (torque_q.size() == 0) begin
                    $display("%0t: unexpected result joint %0d torque %h", $time,
                             m_axis_tuser, m_axis_tdata);
                    o_fail_count++;
                end else begin
                    exp_cmd = torque_q.pop_front();
                    if (exp_cmd.joint !== m_axis_tuser || exp_cmd.torque !== m_axis_tdata) begin
                        $display("%0t: mismatch expected joint %0d torque %h, got %0d %h",
                                 $time, exp_cmd.joint, exp_cmd.torque, m_axis_tuser,
                                 m_axis_tdata);
                        o_fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) predict_torque(s_axis_tdata, s_axis_tuser);
        end
        o_pending = torque_q.size();
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives trajectory loads, commits and joint samples with random idling and
// register settings; the checker predicts and compares every torque command.
// ----------------------------------------------------------------------------
module tb_top import jitc_pkg::*; ();

    localparam int NPTS = 8;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata = '0;
    logic [5:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [31:0]  m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    int           fail_count;
    int           pending;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    bit           hold_recv = 1'b0;

    always #2 i_clk = ~i_clk;

    joint_impedance_trajectory_control DUT (.*);

    jitc_scoreboard u_checker (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .psel, .penable, .pwrite, .paddr, .pwdata,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        m_axis_tready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [31:0] rnd32();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(262143) - 131072;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(input t_opcode op, input logic [2:0] j, input logic [10:0] pidx,
                                input logic [31:0] load, input logic [15:0] period);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= {j, op};
        s_axis_tdata  <= {5'd0, rnd32(), rnd32(), rnd32(), rnd32(), period, load, pidx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        s_axis_tvalid <= 1'b0;
        // the block is busy for at least this cycle after an accept
        @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic load_trajectory(input int npts);
        for (int p = 0; p < npts; p++)
            for (int j = 0; j < 7; j++)
                send_request(OP_LOAD_POINT, 3'(j), 11'(p),
                             $urandom_range(131072) - 65536, 16'd0);
        for (int j = 0; j < 7; j++) begin
            send_request(OP_LOAD_STIFF, 3'(j), 11'd0, rnd32(), 16'd0);
            send_request(OP_LOAD_DAMP, 3'(j), 11'd0, rnd32(), 16'd0);
        end
    endtask

    task automatic random_phase(input int count);
        int k;
        for (k = 0; k < count; k++) begin
            case ($urandom_range(19))
                0: send_request(OP_COMMIT, 3'($urandom), 11'($urandom_range(NPTS)), 32'd0,
                                16'd0);
                1: send_request(OP_LOAD_POINT, 3'($urandom), 11'($urandom_range(NPTS - 1)),
                                rnd32(), 16'd0);
                2: send_request(OP_LOAD_STIFF, 3'($urandom), 11'($urandom), rnd32(), 16'd0);
                3: send_request(OP_LOAD_DAMP, 3'($urandom), 11'($urandom), rnd32(), 16'd0);
                4: send_request(t_opcode'($urandom_range(7, 5)), 3'($urandom),
                                11'($urandom), $urandom, 16'($urandom));
                default: send_request(OP_SAMPLE, 3'($urandom_range(7)), 11'($urandom),
                                      $urandom, 16'($urandom_range(3000)));
            endcase
        end
    endtask

    initial begin
        #100000000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Directed: sample unarmed, every defined opcode and an unknown one, field extremes.
        send_request(OP_SAMPLE, 3'd0, 11'd0, 32'd0, 16'd100);
        send_request(OP_SAMPLE, 3'd7, 11'h7FF, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(OP_LOAD_POINT, 3'd7, 11'd5, 32'd1, 16'd0);
        send_request(OP_LOAD_POINT, 3'd0, 11'h7FF, 32'd1, 16'd0);
        send_request(OP_LOAD_STIFF, 3'd7, 11'd0, 32'd1, 16'd0);
        send_request(t_opcode'(3'd7), 3'd0, 11'd0, 32'd0, 16'd0);
        load_trajectory(NPTS);
        send_request(OP_COMMIT, 3'd0, 11'd1, 32'd0, 16'd0);
        send_request(OP_SAMPLE, 3'd1, 11'd0, 32'd0, 16'd0);
        send_request(OP_COMMIT, 3'd0, 11'h7FF, 32'd0, 16'd0);
        send_request(OP_COMMIT, 3'd0, 11'(NPTS), 32'd0, 16'd0);
        for (int j = 0; j < 7; j++) send_request(OP_SAMPLE, 3'(j), 11'd0, 32'd0, 16'hFFFF);
        send_request(OP_SAMPLE, 3'd0, 11'd0, 32'd0, 16'd500);
        wait_drained();

        write_reg(REG_CORIOLIS, 32'h8000_0000);
        write_reg(REG_INTERVAL, 32'd0);
        write_reg(REG_STEP_LIMIT, 32'h7FFF_FFFF);
        send_request(OP_COMMIT, 3'd0, 11'(NPTS), 32'd0, 16'd0);
        for (int j = 0; j < 7; j++) send_request(OP_SAMPLE, 3'(j), 11'd0, 32'd0, 16'd100);
        wait_drained();

        write_reg(REG_CORIOLIS, 32'h7FFF_FFFF);
        write_reg(REG_INTERVAL, 32'd1);
        write_reg(REG_STEP_LIMIT, 32'd0);
        send_idle_pct = 33; recv_idle_pct = 87;
        send_request(OP_COMMIT, 3'd0, 11'(NPTS), 32'd0, 16'd0);
        random_phase(80);
        // Hold off the receiver while requests keep coming.
        hold_recv = 1'b1;
        fork
            begin
                repeat (1500) @(posedge i_clk);
                hold_recv = 1'b0;
            end
            random_phase(20);
        join
        wait_drained();

        write_reg(REG_CORIOLIS, $urandom);
        write_reg(REG_INTERVAL, 32'hFFFF);
        write_reg(REG_STEP_LIMIT, $urandom_range(200000));
        send_idle_pct = 87; recv_idle_pct = 33;
        send_request(OP_COMMIT, 3'd0, 11'(NPTS), 32'd0, 16'd0);
        random_phase(150);
        wait_drained();

        write_reg(REG_CORIOLIS, 32'h0001_0000);
        write_reg(REG_INTERVAL, 32'd300);
        write_reg(REG_STEP_LIMIT, 32'h0100_0000);
        send_idle_pct = 0; recv_idle_pct = 0;
        load_trajectory(NPTS);
        send_request(OP_COMMIT, 3'd0, 11'(NPTS), 32'd0, 16'd0);
        random_phase(90);
        wait_drained();

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
